// File: hdl/lse_pkg.sv
package lse_pkg;

    // Stream phase, one-hot
    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_LENGTH  = 4'b0010,
        PH_MESSAGE = 4'b0100,
        PH_DONE    = 4'b1000
    } phase_t;

    // Configuration register indexes
    localparam logic [1:0] REG_EMBED_MODE     = 2'd0;
    localparam logic [1:0] REG_HEADER_LENGTH  = 2'd1;
    localparam logic [1:0] REG_MESSAGE_LENGTH = 2'd2;

    localparam logic [7:0] HEADER_LENGTH_RESET = 8'd54;

    // One output word
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } word_t;

    // Words produced by one input word, front to queue
    typedef struct packed {
        logic [1:0] cnt;
        word_t      w0;
        word_t      w1;
    } push_t;

endpackage

// File: hdl/lse_front.sv
module lse_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic [1:0]      cfg_wr_index,
    input  logic [7:0]      cfg_wr_data,
    input  logic            in_fire,
    input  logic [7:0]      carrier_byte,
    input  logic [7:0]      message_byte,
    output lse_pkg::push_t  push
);

    logic                embed_mode_reg;
    logic [7:0]          header_length_reg;
    logic [7:0]          message_length_reg;

    lse_pkg::phase_t     phase_reg, phase_next;
    logic [7:0]          header_count_reg, header_count_next;
    logic [2:0]          bit_position_reg, bit_position_next;
    logic [7:0]          shift_byte_reg, shift_byte_next;
    logic [7:0]          bytes_remaining_reg, bytes_remaining_next;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            embed_mode_reg     <= 1'b0;
            header_length_reg  <= lse_pkg::HEADER_LENGTH_RESET;
            message_length_reg <= 8'd0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_wr_index)
                lse_pkg::REG_EMBED_MODE:     embed_mode_reg     <= cfg_wr_data[0];
                lse_pkg::REG_HEADER_LENGTH:  header_length_reg  <= cfg_wr_data;
                lse_pkg::REG_MESSAGE_LENGTH: message_length_reg <= cfg_wr_data;
                default:                     ;
            endcase
        end
    end

    // Classify the word, advance counters and build the output words
    always_comb
    begin
        lse_pkg::phase_t ph;
        logic [7:0] hc;
        logic [2:0] bp;
        logic [7:0] sb;
        logic [7:0] br;
        logic       bit_v;

        ph = phase_reg;
        hc = header_count_reg;
        bp = bit_position_reg;
        sb = shift_byte_reg;
        br = bytes_remaining_reg;
        bit_v = 1'b0;

        push.cnt     = 2'd0;
        push.w0.data = carrier_byte;
        push.w0.last = 1'b0;
        push.w1.data = carrier_byte;
        push.w1.last = 1'b0;

        if (embed_mode_reg)
        begin
            if (ph == lse_pkg::PH_HEADER && hc < header_length_reg)
            begin
                // Header byte passes through; insert length at its end
                push.cnt = 2'd1;
                hc = hc + 8'd1;
                if (hc == header_length_reg)
                begin
                    push.cnt     = 2'd2;
                    push.w1.data = message_length_reg;
                    br = message_length_reg;
                    bp = 3'd0;
                    sb = 8'd0;
                    ph = (message_length_reg == 8'd0) ? lse_pkg::PH_DONE
                                                       : lse_pkg::PH_MESSAGE;
                end
            end
            else
            begin
                push.cnt = 2'd1;
                if (ph == lse_pkg::PH_HEADER || ph == lse_pkg::PH_LENGTH)
                begin
                    // Length word first, carrier follows
                    push.cnt     = 2'd2;
                    push.w0.data = message_length_reg;
                    br = message_length_reg;
                    bp = 3'd0;
                    sb = 8'd0;
                    ph = (message_length_reg == 8'd0) ? lse_pkg::PH_DONE
                                                       : lse_pkg::PH_MESSAGE;
                end
                if (ph != lse_pkg::PH_MESSAGE || br == 8'd0)
                begin
                    ph = lse_pkg::PH_DONE;
                    push.w1.data = carrier_byte;
                end
                else
                begin
                    // Swap the next message bit, MSB first, into the carrier LSB
                    if (bp == 3'd0)
                    begin
                        sb = message_byte;
                    end
                    bit_v = sb[~bp];
                    bp = bp + 3'd1;
                    if (bp == 3'd0)
                    begin
                        br = br - 8'd1;
                        if (br == 8'd0)
                        begin
                            ph = lse_pkg::PH_DONE;
                        end
                    end
                    push.w1.data = {carrier_byte[7:1], bit_v};
                end
                if (push.cnt == 2'd1)
                begin
                    push.w0.data = push.w1.data;
                end
            end
        end
        else
        begin
            if (ph == lse_pkg::PH_HEADER && hc < header_length_reg)
            begin
                // Drop header byte
                hc = hc + 8'd1;
                if (hc == header_length_reg)
                begin
                    ph = lse_pkg::PH_LENGTH;
                end
            end
            else if (ph == lse_pkg::PH_HEADER || ph == lse_pkg::PH_LENGTH)
            begin
                // Capture the length byte
                br = carrier_byte;
                bp = 3'd0;
                sb = 8'd0;
                ph = (carrier_byte == 8'd0) ? lse_pkg::PH_DONE : lse_pkg::PH_MESSAGE;
            end
            else if (ph == lse_pkg::PH_MESSAGE && br != 8'd0)
            begin
                // Shift in one LSB; emit on a full byte
                sb = {sb[6:0], carrier_byte[0]};
                bp = bp + 3'd1;
                if (bp == 3'd0)
                begin
                    push.cnt     = 2'd1;
                    push.w0.data = sb;
                    push.w0.last = (br == 8'd1);
                    br = br - 8'd1;
                    sb = 8'd0;
                    if (br == 8'd0)
                    begin
                        ph = lse_pkg::PH_DONE;
                    end
                end
            end
            else
            begin
                ph = lse_pkg::PH_DONE;
            end
        end

        if (!in_fire)
        begin
            push.cnt = 2'd0;
        end

        phase_next           = ph;
        header_count_next    = hc;
        bit_position_next    = bp;
        shift_byte_next      = sb;
        bytes_remaining_next = br;
    end

    // Advance state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= lse_pkg::PH_HEADER;
            header_count_reg    <= 8'd0;
            bit_position_reg    <= 3'd0;
            shift_byte_reg      <= 8'd0;
            bytes_remaining_reg <= 8'd0;
        end
        else if (in_fire)
        begin
            phase_reg           <= phase_next;
            header_count_reg    <= header_count_next;
            bit_position_reg    <= bit_position_next;
            shift_byte_reg      <= shift_byte_next;
            bytes_remaining_reg <= bytes_remaining_next;
        end
    end

endmodule

// File: hdl/lse_queue.sv
module lse_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  lse_pkg::push_t  push,
    output logic            room,
    output logic            head_valid,
    output lse_pkg::word_t  head,
    input  logic            pop
);

    localparam int DEPTH = 4;

    lse_pkg::word_t  mem_reg [DEPTH];
    logic [1:0]      wr_ptr_reg, wr_ptr_next;
    logic [1:0]      rd_ptr_reg, rd_ptr_next;
    logic [2:0]      count_reg, count_next;

    // Room for the two words one input can cause
    assign room       = (count_reg <= 3'd2);
    assign head_valid = (count_reg != 3'd0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push.cnt;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push.cnt} - {2'b00, pop};
    end

    // Store up to two words a cycle
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.w0;
        end
        if (push.cnt == 2'd2)
        begin
            mem_reg[wr_ptr_reg + 2'd1] <= push.w1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/lse_back.sv
module lse_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  lse_pkg::word_t  head,
    output logic            pop,
    output logic            out_valid,
    output lse_pkg::word_t  out_word,
    input  logic            out_ready
);

    logic            valid_reg, valid_next;
    lse_pkg::word_t  word_reg;

    // Refill the output register when empty or being taken
    assign pop        = head_valid && (!valid_reg || out_ready);
    assign valid_next = pop || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_word   = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            word_reg <= head;
        end
    end

endmodule

// File: hdl/lsb_stego_embed_extract_core.sv
// LSB steganography engine for a BMP-style byte stream. Each input word
// carries one image byte and the current secret byte; the first
// header_length image bytes pass through (embed) or are dropped (extract).
// Embed inserts the message length as one extra word after the header and
// then hides each message byte, MSB first, in the LSBs of the next eight
// image bytes. Extract takes the byte after the header as the length and
// returns one message byte per eight image bytes, with tlast on the final
// one. An input word is classified and processed in the cycle it is
// accepted; its output words enter a four-word queue and pass from there
// into the output register. Input and output each run at one word per
// cycle while m_tready is not held low; the extra length
// word is absorbed by the queue, and s_tready drops only when the queue
// holds three or more words because the output side is stalling.
module lsb_stego_embed_extract_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_index,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] carrier_byte, [15:8] message_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] data_byte
    output logic        m_tlast    // last_message
);

    lse_pkg::push_t  push;
    lse_pkg::word_t  head;
    lse_pkg::word_t  out_word;
    logic            room;
    logic            head_valid;
    logic            pop;
    logic            in_fire;

    assign s_tready = room;
    assign in_fire  = s_tvalid && room;

    lse_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .in_fire      (in_fire),
        .carrier_byte (s_tdata[7:0]),
        .message_byte (s_tdata[15:8]),
        .push         (push)
    );

    lse_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    lse_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_word   (out_word),
        .out_ready  (m_tready)
    );

    assign m_tdata = out_word.data;
    assign m_tlast = out_word.last;

endmodule

// File: hdl/lse_checker.sv
module lse_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast
);

    // Stalled output word stays offered
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // Stalled output word keeps its payload
    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("m_tdata changed while stalled");

    // Nothing is offered right after reset
    a_no_word_after_reset: assert property (@(posedge clk)
        $past(!rst_n) && rst_n |-> !m_tvalid)
        else $error("output word right after reset");

    // Input side is open right after reset
    a_ready_after_reset: assert property (@(posedge clk)
        $past(!rst_n) && rst_n |-> s_tready)
        else $error("s_tready low right after reset");

endmodule

bind lsb_stego_embed_extract_core lse_checker u_lse_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
